// ===== rtl/smwrr_pkg.sv =====
// shared constants and types for the smooth weighted round-robin picker
// no dependencies
package smwrr_pkg;

  localparam int MaxInstancesDef = 8;
  localparam int WeightBitsDef   = 8;

  localparam int CfgDataW = 64;
  localparam int CfgIdxW  = 1;
  localparam int CountW   = 4;
  localparam int RwW      = 16;
  localparam int PickW    = 3;

  localparam logic [CfgIdxW-1:0] RegInstanceCount = 1'd0;
  localparam logic [CfgIdxW-1:0] RegWeightTable   = 1'd1;

  localparam logic [CountW-1:0]   InstanceCountRst = 4'd8;
  localparam logic [CfgDataW-1:0] WeightTableRst   = 64'h0101_0101_0101_0101;

  localparam logic signed [RwW-1:0] RwMax = 16'sh7fff;
  localparam logic signed [RwW-1:0] RwMin = -16'sh8000;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

endpackage

// ===== rtl/smooth_weighted_round_robin_unit.sv =====
// smooth weighted round-robin picker, top level with sequencer
// depends on smwrr_pkg and smwrr_alu
//
// usage:
//   a request carries healthy_mask_i on in_valid_i/in_ready_o. the block
//   compacts the healthy instances below instance_count, accumulates the
//   weight total, walks the healthy positions adding each weight to its
//   running weight, picks the first strict maximum and takes the total off it.
//   the pick leaves on out_valid_o/out_ready_i as picked_index_o and
//   none_available_o (set when no instance is healthy, state untouched).
//   steps: an accept step, a scan over the first min(MAX_INSTANCES,8)
//   positions, a walk over each healthy position in turn (skipped when
//   none is healthy), a finish step; the single shared adder does the sums.
//   one request is in flight at a time; in_ready_o is high only when idle.
//   a finished pick sits in the output register until taken; a stalled
//   receiver holds the block in its finish step.
//   reset: instance_count 8, all weights 1, running weights and stored
//   count zero. configuration is a plain write port, no read-back.
module smooth_weighted_round_robin_unit
  import smwrr_pkg::*;
#(
  parameter int MAX_INSTANCES = MaxInstancesDef,
  parameter int WEIGHT_BITS   = WeightBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           healthy_mask_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [PickW-1:0]     picked_index_o,
  output logic                 none_available_o
);

  // only the eight mask bits can ever be healthy
  localparam int NPos  = (MAX_INSTANCES < 8) ? MAX_INSTANCES : 8;
  localparam int CW    = $clog2(NPos);
  localparam int NW    = $clog2(NPos + 1);
  localparam int TotW  = WEIGHT_BITS + 3;
  localparam int AW    = ((TotW > RwW) ? TotW : RwW) + 2;
  localparam int ShW   = 7;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  // configuration registers
  logic [CountW-1:0]   inst_cnt_q;
  logic [CfgDataW-1:0] wtab_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inst_cnt_q <= InstanceCountRst;
      wtab_q     <= WeightTableRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegInstanceCount: inst_cnt_q <= cfg_data_i[CountW-1:0];
        RegWeightTable:   wtab_q     <= cfg_data_i;
        default:          ;
      endcase
    end
  end

  // weight of instance idx; bits beyond the table read as zero
  function automatic logic [WEIGHT_BITS-1:0] weight_at(logic [CfgDataW-1:0] tab,
                                                       logic [CW-1:0] idx);
    logic [2*CfgDataW-1:0] ext;
    logic [ShW-1:0]        shamt;
    shamt = ShW'(idx) * ShW'(WEIGHT_BITS);
    ext   = {{CfgDataW{1'b0}}, tab} >> shamt;
    return ext[WEIGHT_BITS-1:0];
  endfunction

  logic [1:0]                 state_q, state_d;
  logic [CW-1:0]              cnt_q, cnt_d;
  logic [NPos-1:0]            mask_q, mask_d;
  logic [NW-1:0]              n_q, n_d;
  logic [NW-1:0]              stored_q, stored_d;
  logic                       clr_q, clr_d;
  logic [TotW-1:0]            total_q, total_d;
  logic [CW-1:0]              p2i_q [NPos];
  logic signed [RwW-1:0]      rw_q [NPos];
  logic signed [RwW-1:0]      best_val_q, best_val_d;
  logic [CW-1:0]              best_pos_q, best_pos_d;
  logic [CW-1:0]              best_inst_q, best_inst_d;
  logic                       none_q, none_d;
  logic                       out_valid_q, out_valid_d;
  logic [PickW-1:0]           pick_q, pick_d;
  logic                       out_none_q, out_none_d;

  // shared adder
  alu_op_e                alu_op;
  logic signed [AW-1:0]   alu_a, alu_b, alu_sum;
  logic signed [RwW-1:0]  alu_sat;

  smwrr_alu #(
    .AW(AW)
  ) u_alu (
    .op_i (alu_op),
    .a_i  (alu_a),
    .b_i  (alu_b),
    .sum_o(alu_sum),
    .sat_o(alu_sat)
  );

  logic [WEIGHT_BITS-1:0] w_scan, w_walk;
  logic signed [RwW-1:0]  rw_old;
  logic                   slot_free;
  logic                   accept;
  logic [NPos-1:0]        mask_lim;

  assign w_scan    = weight_at(wtab_q, cnt_q);
  assign w_walk    = weight_at(wtab_q, p2i_q[cnt_q]);
  assign rw_old    = clr_q ? '0 : rw_q[cnt_q];
  assign slot_free = !out_valid_q || out_ready_i;
  assign accept    = in_valid_i && in_ready_o;

  // health bits at or above the instance limit are dropped
  always_comb begin
    for (int i = 0; i < NPos; i++) begin
      mask_lim[i] = healthy_mask_i[i] && (CountW'(i) < inst_cnt_q);
    end
  end

  // adder operand selection
  always_comb begin
    alu_op = ALU_ADD;
    alu_a  = AW'($signed({1'b0, total_q}));
    alu_b  = AW'($signed({1'b0, w_scan}));
    case (state_q)
      S_WALK: begin
        alu_a = AW'(rw_old);
        alu_b = AW'($signed({1'b0, w_walk}));
      end
      S_FIN: begin
        alu_op = ALU_SUB;
        alu_a  = AW'(best_val_q);
        alu_b  = AW'($signed({1'b0, total_q}));
      end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    mask_d      = mask_q;
    n_d         = n_q;
    stored_d    = stored_q;
    clr_d       = clr_q;
    total_d     = total_q;
    best_val_d  = best_val_q;
    best_pos_d  = best_pos_q;
    best_inst_d = best_inst_q;
    none_d      = none_q;
    out_valid_d = out_valid_q && !out_ready_i;
    pick_d      = pick_q;
    out_none_d  = out_none_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          mask_d  = mask_lim;
          cnt_d   = '0;
          n_d     = '0;
          total_d = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (mask_q[cnt_q]) begin
          n_d     = n_q + NW'(1);
          total_d = alu_sum[TotW-1:0];
        end
        if (cnt_q == CW'(NPos - 1)) begin
          cnt_d = '0;
          if (n_d == '0) begin
            none_d  = 1'b1;
            state_d = S_FIN;
          end else begin
            none_d   = 1'b0;
            clr_d    = (n_d != stored_q);
            stored_d = n_d;
            state_d  = S_WALK;
          end
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      S_WALK: begin
        // first strict maximum wins
        if (cnt_q == '0 || alu_sat > best_val_q) begin
          best_val_d  = alu_sat;
          best_pos_d  = cnt_q;
          best_inst_d = p2i_q[cnt_q];
        end
        if (NW'(cnt_q) + NW'(1) == n_q) begin
          clr_d   = 1'b0;
          state_d = S_FIN;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      S_FIN: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_none_d  = none_q;
          pick_d      = none_q ? '0 : PickW'(best_inst_q);
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      n_q         <= '0;
      stored_q    <= '0;
      clr_q       <= 1'b0;
      none_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NPos; i++) begin
        rw_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      n_q         <= n_d;
      stored_q    <= stored_d;
      clr_q       <= clr_d;
      none_q      <= none_d;
      out_valid_q <= out_valid_d;
      if (state_q == S_WALK) begin
        rw_q[cnt_q] <= alu_sat;
      end else if (state_q == S_FIN && slot_free && !none_q) begin
        rw_q[best_pos_q] <= alu_sat;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    mask_q      <= mask_d;
    total_q     <= total_d;
    best_val_q  <= best_val_d;
    best_pos_q  <= best_pos_d;
    best_inst_q <= best_inst_d;
    pick_q      <= pick_d;
    out_none_q  <= out_none_d;
    if (state_q == S_SCAN && mask_q[cnt_q]) begin
      p2i_q[n_q[CW-1:0]] <= cnt_q;
    end
  end

  assign in_ready_o       = (state_q == S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign picked_index_o   = pick_q;
  assign none_available_o = out_none_q;

`ifndef SYNTHESIS
  a_accept_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_SCAN))
    else $error("accepted request did not start the scan");

  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> (n_q != '0 && NW'(cnt_q) < n_q))
    else $error("walk position beyond healthy count");

  a_none_picks_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && none_available_o) |-> (picked_index_o == '0))
    else $error("none available but index nonzero");

  a_none_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && none_q) |-> $stable(stored_q))
    else $error("stored count changed on an empty request");
`endif

endmodule

// ===== rtl/smwrr_alu.sv =====
// shared add/subtract unit with 16-bit signed saturation
// depends on smwrr_pkg
module smwrr_alu
  import smwrr_pkg::*;
#(
  parameter int AW = 21
) (
  input  alu_op_e                op_i,
  input  logic signed [AW-1:0]   a_i,
  input  logic signed [AW-1:0]   b_i,
  output logic signed [AW-1:0]   sum_o,
  output logic signed [RwW-1:0]  sat_o
);

  localparam logic signed [AW-1:0] MaxExt = AW'(RwMax);
  localparam logic signed [AW-1:0] MinExt = AW'(RwMin);

  always_comb begin
    case (op_i)
      ALU_ADD: sum_o = a_i + b_i;
      ALU_SUB: sum_o = a_i - b_i;
      default: sum_o = a_i + b_i;
    endcase
  end

  // clamp to the running weight range
  always_comb begin
    if (sum_o > MaxExt) begin
      sat_o = RwMax;
    end else if (sum_o < MinExt) begin
      sat_o = RwMin;
    end else begin
      sat_o = sum_o[RwW-1:0];
    end
  end

endmodule

// ===== tb/tb_smooth_weighted_round_robin_unit.sv =====
// self-checking testbench for the smooth weighted round-robin picker
// sends pick requests through a queue-fed driver and checks every pick against
// a built-in predictor; depends on smwrr_pkg and smooth_weighted_round_robin_unit
module tb_smooth_weighted_round_robin_unit;
  import smwrr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // one pick as it leaves the block
  typedef struct packed {
    logic [PickW-1:0] index;
    logic             none_avail;
  } pick_t;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // every input starts at a known value
  logic                cfg_we_i       = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i      = RegInstanceCount;
  logic [CfgDataW-1:0] cfg_data_i     = '0;
  logic                in_valid_i     = 1'b0;
  logic [7:0]          healthy_mask_i = '0;
  logic                out_ready_i    = 1'b0;

  logic             in_ready_o;
  logic             out_valid_o;
  logic [PickW-1:0] picked_index_o;
  logic             none_available_o;

  // requests waiting to be driven, picks waiting to come out
  logic [7:0] pending_masks [$];
  pick_t      expected_picks [$];

  // predictor copy of the configuration and the running state
  logic [CountW-1:0]       cfg_count   = InstanceCountRst;
  logic [CfgDataW-1:0]     cfg_weights = WeightTableRst;
  logic signed [RwW-1:0]   running_wt [MaxInstancesDef];
  logic [CountW-1:0]       stored_count = '0;

  // idle odds in percent, changed between stimulus regimes
  int send_idle_pct = 17;
  int recv_idle_pct = 63;

  int err_cnt     = 0;
  int sent_cnt    = 0;
  int checked_cnt = 0;
  int none_cnt    = 0;
  int setting_cnt = 0;

  pick_t head_pick;

  smooth_weighted_round_robin_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .healthy_mask_i  (healthy_mask_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .picked_index_o  (picked_index_o),
    .none_available_o(none_available_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    foreach (running_wt[i]) running_wt[i] = '0;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // clamp to the 16-bit signed range of a running weight
  function automatic logic signed [RwW-1:0] clamp_rw(input int v);
    if (v > int'(RwMax)) return RwMax;
    if (v < int'(RwMin)) return RwMin;
    return v[RwW-1:0];
  endfunction

  // weight of one instance; bits past the top of the table read as zero
  function automatic int inst_weight(input int inst);
    int pos;
    int w;
    pos = inst * WeightBitsDef;
    w = 0;
    for (int b = 0; b < WeightBitsDef; b++) begin
      if (pos + b < CfgDataW && cfg_weights[pos + b]) w |= (1 << b);
    end
    return w;
  endfunction

  // works out the pick for one request and advances the running state
  function automatic pick_t predict_pick(input logic [7:0] mask);
    int    slot_inst [MaxInstancesDef];
    int    limit;
    int    n;
    int    best;
    int    total;
    pick_t res;
    limit = (cfg_count > MaxInstancesDef) ? MaxInstancesDef : int'(cfg_count);
    n = 0;
    best = 0;
    total = 0;
    res.index = '0;
    res.none_avail = 1'b1;
    // compact the healthy instances in use into positions 0..n-1
    for (int i = 0; i < limit; i++) begin
      if (mask[i]) begin
        slot_inst[n] = i;
        n++;
      end
    end
    // nothing healthy: report it, leave the state alone
    if (n == 0) return res;
    // a different healthy count starts the rotation over
    if (n != int'(stored_count)) begin
      foreach (running_wt[i]) running_wt[i] = '0;
      stored_count = n[CountW-1:0];
    end
    for (int i = 0; i < n; i++) total += inst_weight(slot_inst[i]);
    // first strict maximum wins
    for (int i = 0; i < n; i++) begin
      running_wt[i] = clamp_rw(int'(running_wt[i]) + inst_weight(slot_inst[i]));
      if (running_wt[i] > running_wt[best]) best = i;
    end
    running_wt[best] = clamp_rw(int'(running_wt[best]) - total);
    res.index = PickW'(slot_inst[best]);
    res.none_avail = 1'b0;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: takes requests from the pending queue, predicts on acceptance
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_picks = {expected_picks, predict_pick(healthy_mask_i)};
        sent_cnt++;
      end
      // valid holds with the same mask until the request is taken
      if (!in_valid_i || in_ready_o) begin
        if (pending_masks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i     <= 1'b1;
          healthy_mask_i <= pending_masks.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each accepted pick against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_picks.size() == 0) begin
          err_cnt++;
          $display("%0t: pick with nothing expected, index %0d none %0b",
                   $realtime, picked_index_o, none_available_o);
        end else begin
          head_pick = expected_picks.pop_front();
          checked_cnt++;
          if (head_pick.none_avail) none_cnt++;
          if (picked_index_o !== head_pick.index) begin
            err_cnt++;
            $display("%0t: picked_index expected %0d actual %0d",
                     $realtime, head_pick.index, picked_index_o);
          end
          if (none_available_o !== head_pick.none_avail) begin
            err_cnt++;
            $display("%0t: none_available expected %0b actual %0b",
                     $realtime, head_pick.none_avail, none_available_o);
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // wait until every request went in and every pick came out, then let the
  // block fall back to idle; returns on a falling edge
  task automatic settle();
    @(negedge clk_i);
    while (pending_masks.size() != 0 || in_valid_i || expected_picks.size() != 0)
      @(negedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    // the block is idle here, so the predictor copy can follow right away
    if (idx == RegInstanceCount) cfg_count = data[CountW-1:0];
    else cfg_weights = data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // new setting of both registers; upper data bits of the count write are junk
  // that the block has to ignore
  task automatic apply_config(input logic [CountW-1:0] cnt, input logic [CfgDataW-1:0] wt);
    logic [CfgDataW-1:0] junk;
    junk = {$urandom, $urandom};
    settle();
    write_reg(RegInstanceCount, {junk[CfgDataW-1:CountW], cnt});
    write_reg(RegWeightTable, wt);
    setting_cnt++;
    @(negedge clk_i);
  endtask

  // one random setting followed by a run of requests that mostly keep the
  // same healthy set, so the running weights get to rotate for a while
  task automatic random_phase(input int n_items);
    logic [CountW-1:0]   cnt;
    logic [CfgDataW-1:0] wt;
    logic [7:0]          base;
    logic [7:0]          m;
    int                  wmode;
    int                  r;
    int                  sh;
    case ($urandom_range(9))
      0:       cnt = '0;
      1:       cnt = 4'd1;
      2:       cnt = CountW'($urandom_range(15, 9));
      default: cnt = CountW'($urandom_range(8, 2));
    endcase
    wmode = $urandom_range(5);
    for (int b = 0; b < MaxInstancesDef; b++) begin
      case (wmode)
        0:       wt[b*WeightBitsDef +: WeightBitsDef] = WeightBitsDef'($urandom);
        1:       wt[b*WeightBitsDef +: WeightBitsDef] = WeightBitsDef'($urandom_range(3));
        2:       wt[b*WeightBitsDef +: WeightBitsDef] = '0;
        3:       wt[b*WeightBitsDef +: WeightBitsDef] = '1;
        4:       wt[b*WeightBitsDef +: WeightBitsDef] =
                   WeightBitsDef'($urandom_range(1) ? $urandom : 0);
        default: wt[b*WeightBitsDef +: WeightBitsDef] = WeightBitsDef'($urandom_range(9, 1));
      endcase
    end
    apply_config(cnt, wt);
    base = 8'($urandom_range(255, 1));
    repeat (n_items) begin
      r = $urandom_range(99);
      // now and then the healthy set changes for good
      if (r < 4) base = 8'($urandom_range(255, 1));
      if (r < 75) begin
        m = base;
      end else if (r < 88) begin
        // same number of healthy instances, different members
        sh = $urandom_range(7);
        m = (base << sh) | (base >> (8 - sh));
      end else if (r < 96) begin
        m = 8'($urandom);
      end else begin
        m = '0;
      end
      pending_masks = {pending_masks, m};
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset setting: eight instances, all weights one; empty mask first
    pending_masks = '{8'h00, 8'hff, 8'hff, 8'hff, 8'h01, 8'h80, 8'h0f, 8'h0f};
    setting_cnt++;

    // no instance in use, so nothing is ever available
    apply_config(4'd0, WeightTableRst);
    pending_masks = '{8'hff, 8'h01};

    // count above the maximum saturates; all weights zero keeps position 0
    apply_config(4'd15, '0);
    pending_masks = '{8'hff, 8'hff, 8'h3c};

    // three instances at the largest weight; a mask above the count is empty
    apply_config(4'd3, '1);
    pending_masks = '{8'hff, 8'h04, 8'h07, 8'h07, 8'hf8};

    // uneven weights, one per bit position
    apply_config(4'd8, 64'h0102_0408_1020_4080);
    pending_masks = '{8'hff, 8'hff, 8'haa, 8'h55, 8'hff};

    // random part in three idling regimes
    for (int k = 0; k < 3; k++) begin
      settle();
      case (k)
        0: begin
          send_idle_pct = 17;
          recv_idle_pct = 63;
        end
        1: begin
          send_idle_pct = 63;
          recv_idle_pct = 17;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      repeat (6) random_phase(60);
    end

    // drain, then give the block time to show any stray pick
    settle();
    repeat (25) @(posedge clk_i);

    $display("sent %0d pick requests over %0d register settings, %0d with no instance",
             sent_cnt, setting_cnt, none_cnt);
    $display("checked %0d picks, %0d mismatches", checked_cnt, err_cnt);
    if (err_cnt == 0 && expected_picks.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // hard stop far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("timeout with %0d picks outstanding", expected_picks.size());
    $display("status: fail");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/smwrr_pkg.sv
rtl/smwrr_alu.sv
rtl/smooth_weighted_round_robin_unit.sv
tb/tb_smooth_weighted_round_robin_unit.sv
